/* hdl/suid_pkg.sv */
// Package for the set union / intersection / difference engine.
// Holds sizes, opcode and mode codes and the controller state type.
// No dependencies.
package suid_pkg;

  localparam int SET_CAPACITY = 32;
  localparam int ADDR_W       = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
  localparam int ELEM_W       = 16;
  localparam int IDX_W        = 16;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] MODE_UNION = 2'd0;
  localparam logic [1:0] MODE_INTER = 2'd1;
  localparam logic [1:0] MODE_DIFF  = 2'd2;

  localparam logic [IDX_W-1:0] IDX_SAT = {IDX_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } suid_state_t;

  // Whether a queried element enters the result set.
  function automatic logic query_emits(input logic [1:0] mode, input logic found);
    logic res;
    res = 1'b0;
    unique case (mode)
      MODE_INTER: res = found;
      MODE_UNION,
      MODE_DIFF:  res = !found;
      default:    res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* hdl/suid_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the set A store. Depends on nothing.
module suid_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/set_union_intersect_difference.sv */
// Set union / intersection / difference engine: top level.
// Depends on suid_pkg and suid_ram.
//
// Usage:
//   Input requests (in_valid / in_stall) carry an opcode and an element.
//   Clear empties set A and restarts result numbering; load appends an
//   element to A (emitted as well in union mode); query searches A for an
//   element of B and emits it according to set_mode. Results leave on the
//   out_ channel with member_value, result_index (saturating at 65535) and
//   status, which is 1 for a load dropped because A is full.
//   set_mode is written over the APB-style port at byte address 0, by the
//   user only while the block is idle (not enforced); pready is always high.
// Sequence:
//   Clear and unused opcodes finish when accepted. A load goes on to the emit
//   step when it produces a result. A query reads n entries of A, one per
//   cycle through the store's single read port, n the number read before a
//   match or the end of A (n <= set_a_count <= 32), then goes on to the emit
//   step when it emits. A result appears in the cycle after the emit step.
// Reset: synchronous, clears set_a_count, the result counter and set_mode.
//   The store itself is not cleared; only written entries are ever read.
// Stall: a waiting result sits in the output register; the next request is
//   still accepted, but an item needing the occupied output waits, stalling input.
module set_union_intersect_difference
  import suid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [ELEM_W-1:0] in_element_value,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ELEM_W-1:0] out_member_value,
  output logic [IDX_W-1:0]  out_result_index,
  output logic              out_status,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  suid_state_t state_r, state_nxt;

  logic [1:0]        mode_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  emitted_r, emitted_nxt;
  logic [ELEM_W-1:0] key_r, key_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;

  logic [ELEM_W-1:0] pend_val_r, pend_val_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic              pend_st_r, pend_st_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] out_val_r, out_val_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_st_r, out_st_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ELEM_W-1:0] ram_rdata;

  logic acc, full, cfg_wr, out_free;
  logic scan_hit, scan_last, scan_done;

  assign acc       = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(SET_CAPACITY));
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_hit  = (ram_rdata == key_r);
  assign scan_last = (CNT_W'(idx_r) == count_r - CNT_W'(1));
  assign scan_done = scan_hit || scan_last;

  assign in_stall = (state_r != ST_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[CFG_AW-1] == 1'b0) ? {{(CFG_DW - 2){1'b0}}, mode_r} : '0;

  assign out_valid        = out_valid_r;
  assign out_member_value = out_val_r;
  assign out_result_index = out_idx_r;
  assign out_status       = out_st_r;

  suid_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (SET_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_element_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_opcode)
            OP_LOAD: begin
              if (full || mode_r == MODE_UNION) state_nxt = ST_EMIT;
            end
            OP_QUERY: begin
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end else if (query_emits(mode_r, 1'b0)) begin
                state_nxt = ST_EMIT;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = query_emits(mode_r, scan_hit) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt    = count_r;
    emitted_nxt  = emitted_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    pend_val_nxt = pend_val_r;
    pend_idx_nxt = pend_idx_r;
    pend_st_nxt  = pend_st_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = idx_r + ADDR_W'(1);

    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_opcode)
            OP_CLEAR: begin
              count_nxt   = '0;
              emitted_nxt = '0;
            end
            OP_LOAD: begin
              pend_val_nxt = in_element_value;
              if (full) begin
                pend_idx_nxt = '0;
                pend_st_nxt  = 1'b1;
              end else begin
                ram_we       = 1'b1;
                count_nxt    = count_r + CNT_W'(1);
                pend_idx_nxt = emitted_r;
                pend_st_nxt  = 1'b0;
                if (mode_r == MODE_UNION && emitted_r != IDX_SAT) begin
                  emitted_nxt = emitted_r + IDX_W'(1);
                end
              end
            end
            OP_QUERY: begin
              key_nxt      = in_element_value;
              pend_val_nxt = in_element_value;
              pend_idx_nxt = emitted_r;
              pend_st_nxt  = 1'b0;
              if (count_r != '0) begin
                // start the walk at entry 0
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
              end else if (query_emits(mode_r, 1'b0) && emitted_r != IDX_SAT) begin
                emitted_nxt = emitted_r + IDX_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (query_emits(mode_r, scan_hit) && emitted_r != IDX_SAT) begin
            emitted_nxt = emitted_r + IDX_W'(1);
          end
        end else begin
          // advance to the next stored entry
          ram_re  = 1'b1;
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = pend_val_r;
          out_idx_nxt   = pend_idx_r;
          out_st_nxt    = pend_st_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_UNION;
      count_r     <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && paddr[CFG_AW-1] == 1'b0) begin
        mode_r <= pwdata[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    pend_val_r <= pend_val_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_st_r  <= pend_st_nxt;
    out_val_r  <= out_val_nxt;
    out_idx_r  <= out_idx_nxt;
    out_st_r   <= out_st_nxt;
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !full)
    else $error("store written while full");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SET_CAPACITY))
    else $error("set A count beyond capacity");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("pending result not moved to output");

  a_full_status_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r) |-> (out_idx_r == '0))
    else $error("dropped load carries a nonzero index");

endmodule

/* test/set_union_intersect_difference_test.sv */
// Testbench for the set union / intersection / difference engine.
// Drives clear, load and query requests under every set_mode and checks each result
// against a behavioural predictor of set A. Depends on suid_pkg.
module set_union_intersect_difference_test;
  import suid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = SET_CAPACITY + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 24;

  localparam logic [1:0] OP_NOP    = 2'd3;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [CFG_AW-1:0] ADDR_SET_MODE = '0;

  typedef struct packed {
    logic [ELEM_W-1:0] member;
    logic [IDX_W-1:0]  index;
    logic              status;
  } member_rec_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = OP_CLEAR;
  logic [ELEM_W-1:0] in_element_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ELEM_W-1:0] out_member_value;
  logic [IDX_W-1:0]  out_result_index;
  logic              out_status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // predictor state
  logic [ELEM_W-1:0] a_members [SET_CAPACITY];
  int                a_size = 0;
  logic [IDX_W-1:0]  next_index = '0;
  logic [1:0]        mode_shadow = MODE_UNION;
  member_rec_t       pending_members[$];

  int  errors = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  int  hold_asked = 0;
  int  hold_done = 0;
  int  hold_left = 0;

  set_union_intersect_difference uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_member_value (out_member_value),
    .out_result_index (out_result_index),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_members.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_asked;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic void note_error();
    errors++;
  endfunction

  function automatic void emit_member(input logic [ELEM_W-1:0] val);
    pending_members.push_back('{member: val, index: next_index, status: 1'b0});
    if (next_index != IDX_SAT) next_index++;
  endfunction

  function automatic void predict_request(input logic [1:0] op, input logic [ELEM_W-1:0] val);
    bit found;
    found = 1'b0;
    case (op)
      OP_CLEAR: begin
        a_size = 0;
        next_index = '0;
      end
      OP_LOAD: begin
        if (a_size >= SET_CAPACITY) begin
          pending_members.push_back('{member: val, index: '0, status: 1'b1});
        end else begin
          a_members[a_size] = val;
          a_size++;
          if (mode_shadow == MODE_UNION) emit_member(val);
        end
      end
      OP_QUERY: begin
        for (int k = 0; k < a_size; k++)
          if (a_members[k] == val) found = 1'b1;
        case (mode_shadow)
          MODE_INTER: if (found) emit_member(val);
          MODE_UNION, MODE_DIFF: if (!found) emit_member(val);
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Result checker: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    member_rec_t exp_rec;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_members.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual member %h index %h status %b",
                 $time, out_member_value, out_result_index, out_status);
        note_error();
      end else begin
        exp_rec = pending_members.pop_front();
        if (out_member_value !== exp_rec.member) begin
          $display("%0t: member_value: expected %h actual %h",
                   $time, exp_rec.member, out_member_value);
          note_error();
        end
        if (out_result_index !== exp_rec.index) begin
          $display("%0t: result_index: expected %h actual %h",
                   $time, exp_rec.index, out_result_index);
          note_error();
        end
        if (out_status !== exp_rec.status) begin
          $display("%0t: status: expected %b actual %b", $time, exp_rec.status, out_status);
          note_error();
        end
      end
    end
  end

  // Offer one request and hold it until accepted; valid stays high afterwards.
  task automatic send_req(input logic [1:0] op, input logic [ELEM_W-1:0] val);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_element_value <= val;
    do @(posedge clk); while (in_stall);
    predict_request(op, val);
  endtask

  // Wait until every expected result is out and the block has settled.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_members.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SET_MODE;
    pwdata  <= CFG_DW'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode_shadow = m;
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(m)) begin
      $display("%0t: set_mode readback: expected %h actual %h", $time, CFG_DW'(m), prdata);
      note_error();
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Half the time reuse a member of A, so that queries hit and loads duplicate.
  function automatic logic [ELEM_W-1:0] pick_value();
    if (a_size > 0 && $urandom_range(1) == 0)
      return a_members[$urandom_range(a_size - 1)];
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    // reset mode is union
    send_req(OP_QUERY, 16'h0000);
    send_req(OP_LOAD,  16'hFFFF);
    send_req(OP_LOAD,  16'h0000);
    send_req(OP_QUERY, 16'hFFFF);
    send_req(OP_QUERY, 16'h8001);
    send_req(OP_NOP,   16'hFFFF);
    send_req(OP_CLEAR, 16'h5A5A);
    send_req(OP_QUERY, 16'hFFFF);
    drain_results();
    write_mode(MODE_INTER);
    send_req(OP_LOAD,  16'h0005);
    send_req(OP_LOAD,  16'h0005);
    send_req(OP_LOAD,  16'hAAAA);
    send_req(OP_QUERY, 16'h0005);
    send_req(OP_QUERY, 16'h5555);
    send_req(OP_QUERY, 16'h0005);
    send_req(OP_QUERY, 16'hAAAA);
    drain_results();
    write_mode(MODE_DIFF);
    send_req(OP_QUERY, 16'h0005);
    send_req(OP_QUERY, 16'h5555);
    send_req(OP_QUERY, 16'h5555);
    drain_results();
    write_mode(MODE_NONE);
    send_req(OP_LOAD,  16'h1234);
    send_req(OP_QUERY, 16'h1234);
    send_req(OP_QUERY, 16'h4321);
  endtask

  // Mostly clean clear / load / query runs, some stray requests in between.
  task automatic test_random_mode(input logic [1:0] m, input int n);
    int sent;
    int nload;
    int nquery;
    drain_results();
    write_mode(m);
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 10) begin
        if ($urandom_range(1)) begin
          send_req(OP_NOP, ELEM_W'($urandom));
        end else begin
          send_req($urandom_range(1) ? OP_LOAD : OP_QUERY, pick_value());
          sent++;
        end
      end else begin
        send_req(OP_CLEAR, ELEM_W'($urandom));
        nload  = ($urandom_range(7) == 0) ? $urandom_range(30, SET_CAPACITY + 4)
                                          : $urandom_range(0, 10);
        nquery = $urandom_range(1, 12);
        repeat (nload) send_req(OP_LOAD, pick_value());
        repeat (nquery) send_req(OP_QUERY, pick_value());
        sent += 1 + nload + nquery;
      end
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    test_random_mode(MODE_DIFF, 60);
    drain_results();
    calm = 1'b0;
  endtask

  // Hold the receiver off while queries keep arriving, so the block backs up.
  task automatic test_backpressure();
    drain_results();
    write_mode(MODE_UNION);
    send_req(OP_CLEAR, 16'h0000);
    hold_asked++;
    repeat (40) send_req(OP_QUERY, ELEM_W'($urandom));
  endtask

  // Fill set A past capacity, so that the last loads are dropped with a full status.
  task automatic test_store_full();
    drain_results();
    write_mode(MODE_UNION);
    calm = 1'b1;
    send_req(OP_CLEAR, 16'h0000);
    repeat (SET_CAPACITY + 2) send_req(OP_LOAD, ELEM_W'($urandom));
    send_req(OP_QUERY, ELEM_W'($urandom));
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mode(MODE_UNION, 90);
    test_random_mode(MODE_INTER, 90);
    test_random_mode(MODE_DIFF, 90);
    test_random_mode(MODE_NONE, 50);
    test_back_to_back();
    test_backpressure();
    test_random_mode(MODE_INTER, 55);
    test_random_mode(MODE_UNION, 55);
    test_store_full();
    drain_results();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* set_union_intersect_difference.f */
hdl/suid_pkg.sv
hdl/suid_ram.sv
hdl/set_union_intersect_difference.sv
test/set_union_intersect_difference_test.sv
